>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files; s370_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> hw/rtl/s370_pkg.sv
package s370_pkg;
  localparam logic [1:0] OP_EXEC = 2'd0;
  localparam logic [1:0] OP_LOADB = 2'd1;
  localparam logic [1:0] OP_SETR = 2'd2;

  localparam logic [7:0] OPC_BALR = 8'h05;
  localparam logic [7:0] OPC_BCR = 8'h07;
  localparam logic [7:0] OPC_ST = 8'h50;
  localparam logic [7:0] OPC_L = 8'h58;
  localparam logic [7:0] OPC_A = 8'h5A;
  localparam logic [7:0] OPC_S = 8'h5B;
  localparam logic [7:0] OPC_LR = 8'h18;
  localparam logic [7:0] OPC_LA = 8'h41;
  localparam logic [7:0] OPC_AR = 8'h1A;
  localparam logic [7:0] OPC_MVC = 8'hD2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_MISALIGN = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_HALT = 3'd4;

  typedef enum logic [2:0] {
    K_NONE = 3'd0, K_DONE = 3'd1, K_LOAD = 3'd2, K_STORE = 3'd3, K_MVC = 3'd4
  } kind_t;

  typedef struct packed {
    logic latch;
    logic mem_step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic last;
  } dp_status_t;
endpackage

>>> hw/rtl/s370_ram.sv
module s370_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/s370_ctrl.sv
`include "assert_macros.svh"
module s370_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  s370_pkg::dp_status_t  sts,
  output s370_pkg::ctl_cmd_t    cmd,
  output logic                  busy
);
  import s370_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_DECODE = 4'b0010, S_MEM = 4'b0100, S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.kind == K_LOAD || sts.kind == K_STORE || sts.kind == K_MVC) begin
          state_nxt = S_MEM;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MEM: begin
        cmd.mem_step = 1'b1;
        if (sts.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMPLIES(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))
  `ASSERT_NEXT(a_done_idle, clk, rst_n, cmd.finish, !busy)
endmodule

>>> hw/rtl/s370_dp.sv
module s370_dp #(
  parameter int MEM_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  s370_pkg::ctl_cmd_t   cmd,
  output s370_pkg::dp_status_t sts,
  input  logic [23:0]          cfg_origin,
  input  logic [1:0]           in_operation,
  input  logic [23:0]          in_instr_addr,
  input  logic [7:0]           in_opcode,
  input  logic [7:0]           in_second_byte,
  input  logic [15:0]          in_first_base_disp,
  input  logic [15:0]          in_second_base_disp,
  input  logic [11:0]          in_load_index,
  input  logic [31:0]          in_load_value,
  output logic                 out_strobe,
  output logic [2:0]           out_status,
  output logic                 out_branch_taken,
  output logic [23:0]          out_branch_target,
  output logic                 out_reg_written,
  output logic [3:0]           out_reg_number,
  output logic [31:0]          out_reg_value,
  output logic [23:0]          out_effective_addr
);
  import s370_pkg::*;
  localparam int AW = $clog2(MEM_BYTES);

  logic [1:0]  op_r;
  logic [23:0] ia_r;
  logic [7:0]  opc_r, sb_r;
  logic [15:0] bd1_r, bd2_r;
  logic [11:0] li_r;
  logic [31:0] lv_r;
  logic [31:0] gpr_r [16];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_operation; ia_r <= in_instr_addr; opc_r <= in_opcode;
      sb_r <= in_second_byte; bd1_r <= in_first_base_disp;
      bd2_r <= in_second_base_disp; li_r <= in_load_index; lv_r <= in_load_value;
    end
  end

  logic [3:0] r1, r2;
  assign r1 = sb_r[7:4];
  assign r2 = sb_r[3:0];
  logic [31:0] v1, v2, vb1, vb2, vx;
  assign v1 = gpr_r[r1];
  assign v2 = gpr_r[r2];
  assign vb1 = (bd1_r[15:12] == 4'd0) ? 32'd0 : gpr_r[bd1_r[15:12]];
  assign vb2 = (bd2_r[15:12] == 4'd0) ? 32'd0 : gpr_r[bd2_r[15:12]];
  assign vx = (r2 == 4'd0) ? 32'd0 : v2;

  logic [23:0] ea_rx, ea_d, ea_s, ix_d, ix_s, ix_rx;
  assign ea_rx = vb1[23:0] + vx[23:0] + {12'd0, bd1_r[11:0]};
  assign ea_d = vb1[23:0] + {12'd0, bd1_r[11:0]};
  assign ea_s = vb2[23:0] + {12'd0, bd2_r[11:0]};
  assign ix_rx = ea_rx - cfg_origin;
  assign ix_d = ea_d - cfg_origin;
  assign ix_s = ea_s - cfg_origin;
  logic [24:0] len;
  assign len = {17'd0, sb_r} + 25'd1;
  logic fit_rx, fit_d, fit_s;
  assign fit_rx = ({1'b0, ix_rx} + 25'd4) <= 25'(MEM_BYTES);
  assign fit_d = ({1'b0, ix_d} + len) <= 25'(MEM_BYTES);
  assign fit_s = ({1'b0, ix_s} + len) <= 25'(MEM_BYTES);

  logic       is_rx;
  assign is_rx = opc_r == OPC_ST || opc_r == OPC_L || opc_r == OPC_A ||
                 opc_r == OPC_S || opc_r == OPC_LA;

  // Decode outcome, combinational over the latched instruction.
  kind_t       kind;
  logic [2:0]  st;
  logic        bt, rw;
  logic [23:0] btg, ea;
  logic [3:0]  rn;
  logic [31:0] rv;
  always_comb begin
    kind = K_DONE; st = ST_OK; bt = 1'b0; btg = '0; rw = 1'b0; rn = '0; rv = '0;
    ea = '0;
    case (op_r)
      OP_LOADB: begin
        if ({20'd0, li_r} >= 32'(MEM_BYTES)) st = ST_RANGE;
      end
      OP_SETR: begin
        rw = 1'b1; rn = li_r[3:0]; rv = lv_r;
      end
      OP_EXEC: begin
        if (opc_r == OPC_BALR) begin
          rw = 1'b1; rn = r1; rv = {8'd0, ia_r + 24'd2};
          if (r2 != 4'd0) begin bt = 1'b1; btg = v2[23:0]; end
        end else if (opc_r == OPC_BCR) begin
          if (r1 != 4'hF) st = ST_HALT;
          else if (r2 != 4'd0) begin
            if (v2 == 32'd0) st = ST_HALT;
            else begin bt = 1'b1; btg = v2[23:0]; end
          end
        end else if (opc_r == OPC_LR) begin
          rw = 1'b1; rn = r1; rv = v2;
        end else if (opc_r == OPC_AR) begin
          rw = 1'b1; rn = r1; rv = v1 + v2;
        end else if (is_rx) begin
          ea = ea_rx;
          if (ea_rx[1:0] != 2'd0) st = ST_MISALIGN;
          else if (opc_r == OPC_LA) begin rw = 1'b1; rn = r1; rv = {8'd0, ea_rx}; end
          else if (!fit_rx) st = ST_RANGE;
          else if (opc_r == OPC_ST) kind = K_STORE;
          else begin kind = K_LOAD; rw = 1'b1; rn = r1; end
        end else if (opc_r == OPC_MVC) begin
          ea = ea_d;
          if (ea_s[1:0] != 2'd0) st = ST_MISALIGN;
          else if (!fit_d || !fit_s) st = ST_RANGE;
          else kind = K_MVC;
        end else begin
          st = ST_UNKNOWN;
        end
      end
      default: st = ST_UNKNOWN;
    endcase
  end

  // Result holding registers and memory walk.
  kind_t       kind_r;
  logic [2:0]  st_r;
  logic        bt_r, rw_r;
  logic [23:0] btg_r, ea_r;
  logic [3:0]  rn_r;
  logic [31:0] rv_r, acc_r, sw_r;
  logic [AW-1:0] src_r, dst_r;
  logic [8:0]  cnt_r, tot_r;
  logic        rd_v_r;

  logic          mwe, rd_ok;
  logic [AW-1:0] mwa, mra;
  logic [7:0]    mwd, mrd;
  logic          decode_cyc;

  always_ff @(posedge clk) begin
    if (!rst_n) decode_cyc <= 1'b0;
    else decode_cyc <= cmd.latch;
  end

  assign rd_ok = rd_v_r;
  assign sts.kind = decode_cyc ? kind : kind_r;
  assign sts.last = (kind_r == K_STORE) ? (cnt_r == 9'd3) :
                    (rd_v_r && cnt_r == tot_r - 9'd1);

  always_comb begin
    mwe = 1'b0; mwa = dst_r; mwd = mrd; mra = src_r;
    if (cmd.latch && in_operation == OP_LOADB &&
        {20'd0, in_load_index} < 32'(MEM_BYTES)) begin
      mwe = 1'b1; mwa = AW'(in_load_index); mwd = in_load_value[7:0];
    end else if (cmd.mem_step && kind_r == K_STORE) begin
      mwe = 1'b1; mwd = sw_r[31:24];
    end else if (cmd.mem_step && kind_r == K_MVC && rd_ok) begin
      mwe = 1'b1;
    end
  end

  s370_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mwe), .waddr(mwa), .wdata(mwd), .raddr(mra), .rdata(mrd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) gpr_r[i] <= 32'd0;
      kind_r <= K_NONE;
      out_strobe <= 1'b0;
      rd_v_r <= 1'b0;
    end else begin
      out_strobe <= cmd.finish;
      if (decode_cyc) begin
        kind_r <= kind; st_r <= st; bt_r <= bt; btg_r <= btg; rw_r <= rw;
        rn_r <= rn; rv_r <= rv; ea_r <= ea; cnt_r <= '0; rd_v_r <= 1'b0;
        sw_r <= v1; acc_r <= v1;
        tot_r <= (kind == K_MVC) ? len[8:0] : 9'd4;
        src_r <= (kind == K_MVC) ? ix_s[AW-1:0] : ix_rx[AW-1:0];
        dst_r <= (kind == K_MVC) ? ix_d[AW-1:0] : ix_rx[AW-1:0];
        if (kind == K_DONE && rw) gpr_r[rn] <= rv;
      end else if (cmd.mem_step) begin
        case (kind_r)
          K_STORE: begin
            sw_r <= {sw_r[23:0], 8'd0}; dst_r <= dst_r + AW'(1); cnt_r <= cnt_r + 9'd1;
          end
          K_LOAD: begin
            src_r <= src_r + AW'(1); rd_v_r <= 1'b1;
            if (rd_v_r) begin
              acc_r <= {acc_r[23:0], mrd}; cnt_r <= cnt_r + 9'd1;
            end
          end
          K_MVC: begin
            // Read precedes write; the next read must see this write.
            rd_v_r <= ~rd_v_r;
            if (rd_v_r) begin
              dst_r <= dst_r + AW'(1); src_r <= src_r + AW'(1); cnt_r <= cnt_r + 9'd1;
            end
          end
          default: ;
        endcase
      end else if (cmd.finish && kind_r == K_LOAD) begin
        if (opc_r == OPC_L) begin rv_r <= acc_r; gpr_r[rn_r] <= acc_r; end
        else if (opc_r == OPC_A) begin rv_r <= sw_r + acc_r; gpr_r[rn_r] <= sw_r + acc_r; end
        else begin rv_r <= sw_r - acc_r; gpr_r[rn_r] <= sw_r - acc_r; end
      end
    end
  end

  assign out_status = st_r;
  assign out_branch_taken = bt_r;
  assign out_branch_target = btg_r;
  assign out_reg_written = rw_r;
  assign out_reg_number = rn_r;
  assign out_reg_value = rv_r;
  assign out_effective_addr = ea_r;
endmodule

>>> hw/rtl/s370_subset_instruction_unit.sv
// Instruction unit for a small System/370 subset.
// Input: raise start with the in_ fields; a beat is taken when start is high
// and busy is low. operation 0 executes one instruction, 1 writes one memory
// byte, 2 sets one general register.
// Output: one result beat per input, shown for exactly one cycle while
// out_strobe is high. The receiver cannot stall; results are never held.
// Configuration: cfg_we with cfg_wdata writes the program origin; write only
// while busy is low.
// From accept to strobe the controller steps through DECODE, then MEM for
// loads, stores and MVC, then DONE; out_strobe is registered from DONE. The
// byte-wide memory sets the length of MEM: a word takes four byte
// accesses, and MVC reads and writes each byte in turn.
// Busy drops while the result is shown, so a new beat can be taken at the
// edge that ends the strobe cycle; each item holds the unit until its result is shown.
// Reset clears the general registers, the origin and the controller. Memory content
// is undefined until written.
module s370_subset_instruction_unit #(
  parameter int MEM_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic [1:0]  in_operation,
  input  logic [23:0] in_instr_addr,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_second_byte,
  input  logic [15:0] in_first_base_disp,
  input  logic [15:0] in_second_base_disp,
  input  logic [11:0] in_load_index,
  input  logic [31:0] in_load_value,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic        out_branch_taken,
  output logic [23:0] out_branch_target,
  output logic        out_reg_written,
  output logic [3:0]  out_reg_number,
  output logic [31:0] out_reg_value,
  output logic [23:0] out_effective_addr
);
  import s370_pkg::*;

  logic [23:0] origin_r;
  ctl_cmd_t    cmd;
  dp_status_t  sts;

  always_ff @(posedge clk) begin
    if (!rst_n) origin_r <= 24'd0;
    else if (cfg_we) origin_r <= cfg_wdata;
  end

  s370_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  s370_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cfg_origin(origin_r),
    .in_operation(in_operation), .in_instr_addr(in_instr_addr),
    .in_opcode(in_opcode), .in_second_byte(in_second_byte),
    .in_first_base_disp(in_first_base_disp),
    .in_second_base_disp(in_second_base_disp),
    .in_load_index(in_load_index), .in_load_value(in_load_value),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_branch_taken(out_branch_taken), .out_branch_target(out_branch_target),
    .out_reg_written(out_reg_written), .out_reg_number(out_reg_number),
    .out_reg_value(out_reg_value), .out_effective_addr(out_effective_addr)
  );
endmodule
